>>> src/asu_pkg.sv
package asu_pkg;

  // Default sizes of the sketch store and the key
  localparam int unsigned MAX_ROWS_DEF      = 8;
  localparam int unsigned MAX_COUNTERS_DEF  = 1024;
  localparam int unsigned MAX_KEY_BYTES_DEF = 8;

  // Field widths of the stream words
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned RROW_W     = 3;
  localparam int unsigned RCOL_W     = 10;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 64;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned NROWS_W    = 4;
  localparam int unsigned NCOLS_W    = 11;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTERS = 2'd1;
  localparam logic [NROWS_W-1:0]   ROWS_RESET     = 4'd8;
  localparam logic [NCOLS_W-1:0]   COUNTERS_RESET = 11'd1024;

  // Operation codes carried in tuser
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Hash constants
  localparam logic [31:0] MURMUR_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MURMUR_C2 = 32'h1b873593;
  localparam logic [31:0] MURMUR_C3 = 32'he6546b64;
  localparam logic [31:0] MURMUR_C4 = 32'h85ebca6b;
  localparam logic [31:0] MURMUR_C5 = 32'hc2b2ae35;

  // Remainder pipeline: eight quotient bits per stage
  localparam int unsigned MOD_STAGES = 4;
  localparam int unsigned MOD_BITS   = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_ISSUE,
    ST_DRAIN,
    ST_READ,
    ST_READ_WAIT,
    ST_FINISH
  } asu_state_t;

  typedef struct packed {
    logic               is_sign;
    logic [NROWS_W-1:0] row;
  } hash_tag_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned s);
    rotl32 = (x << s) | (x >> (32 - s));
  endfunction

  // One body round of the hash: fold in a mixed block, rotate, scale by five, add a constant
  function automatic logic [31:0] body_round(input logic [31:0] h, input logic [31:0] m);
    logic [31:0] t;
    t = rotl32(h ^ m, 13);
    body_round = (t << 2) + t + MURMUR_C3;
  endfunction

  // Restoring remainder over one byte of the dividend, most significant bit first
  function automatic logic [NCOLS_W-1:0] mod_step(input logic [NCOLS_W-1:0] rem,
                                                  input logic [MOD_BITS-1:0] bits,
                                                  input logic [NCOLS_W-1:0] d);
    logic [NCOLS_W:0]   t;
    logic [NCOLS_W-1:0] r;
    r = rem;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r = t[NCOLS_W-1:0];
    end
    mod_step = r;
  endfunction

endpackage

>>> src/asu_counters.sv
module asu_counters #(
  parameter int unsigned ADDR_W = 13,
  parameter int unsigned DEPTH  = 8192
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/asu_hash.sv
module asu_hash (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [31:0]                   key_word0,
  input  logic [31:0]                   key_word1,
  input  logic [asu_pkg::LEN_W-1:0]     key_len,
  input  logic                          in_valid,
  input  logic [31:0]                   in_seed,
  input  asu_pkg::hash_tag_t            in_tag,
  output logic                          out_valid,
  output logic [31:0]                   out_hash,
  output asu_pkg::hash_tag_t            out_tag
);

  // The block mixing depends on the key alone, so it runs once for both words
  // and is registered first in p0/p1, then in m0/m1.
  logic [31:0] p0, p1, m0, m1;

  always_ff @(posedge clk) begin
    p0 <= key_word0 * asu_pkg::MURMUR_C1;
    p1 <= key_word1 * asu_pkg::MURMUR_C1;
    m0 <= asu_pkg::rotl32(p0, 15) * asu_pkg::MURMUR_C2;
    m1 <= asu_pkg::rotl32(p1, 15) * asu_pkg::MURMUR_C2;
  end

  logic [3:0]         valid_q;
  asu_pkg::hash_tag_t tag_q [4];
  logic [31:0]        h1, h2, h3, h4;
  logic [31:0]        h1_next, h2_next;

  always_comb begin
    if (key_len >= 4'd4) begin
      h1_next = asu_pkg::body_round(in_seed, m0);
    end else if (key_len >= 4'd1) begin
      h1_next = in_seed ^ m0;
    end else begin
      h1_next = in_seed;
    end
  end

  always_comb begin
    h2_next = h1;
    if (key_len == 4'd8) begin
      h2_next = asu_pkg::body_round(h1, m1);
    end else if (key_len >= 4'd5) begin
      h2_next = h1 ^ m1;
    end
    h2_next = h2_next ^ 32'(key_len);
    h2_next = h2_next ^ (h2_next >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_q[0] <= in_tag;
    tag_q[1] <= tag_q[0];
    tag_q[2] <= tag_q[1];
    tag_q[3] <= tag_q[2];
    h1 <= h1_next;
    h2 <= h2_next;
    h3 <= h2 * asu_pkg::MURMUR_C4;
    h4 <= (h3 ^ (h3 >> 13)) * asu_pkg::MURMUR_C5;
  end

  assign out_valid = valid_q[3];
  assign out_tag   = tag_q[3];
  assign out_hash  = h4 ^ (h4 >> 16);

endmodule

>>> src/asu_mod.sv
module asu_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [asu_pkg::NCOLS_W-1:0] divisor,
  input  logic                        in_valid,
  input  logic [31:0]                 in_value,
  input  logic [asu_pkg::NROWS_W-1:0] in_row,
  output logic                        out_valid,
  output logic [asu_pkg::NCOLS_W-1:0] out_rem,
  output logic [asu_pkg::NROWS_W-1:0] out_row
);

  localparam int unsigned NS = asu_pkg::MOD_STAGES;
  localparam int unsigned NB = asu_pkg::MOD_BITS;

  logic [NS-1:0]               valid_q;
  logic [asu_pkg::NCOLS_W-1:0] rem_q [NS];
  logic [31:0]                 val_q [NS];
  logic [asu_pkg::NROWS_W-1:0] row_q [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-2:0], in_valid};
    end
  end

  // Each stage folds the next byte of the hash into the running remainder.
  always_ff @(posedge clk) begin
    rem_q[0] <= asu_pkg::mod_step('0, in_value[31 -: NB], divisor);
    val_q[0] <= in_value;
    row_q[0] <= in_row;
    for (int k = 1; k < NS; k++) begin
      rem_q[k] <= asu_pkg::mod_step(rem_q[k-1], val_q[k-1][31 - k * NB -: NB], divisor);
      val_q[k] <= val_q[k-1];
      row_q[k] <= row_q[k-1];
    end
  end

  assign out_valid = valid_q[NS-1];
  assign out_rem   = rem_q[NS-1];
  assign out_row   = row_q[NS-1];

endmodule

>>> src/ams_sketch_update.sv
// AMS sketch update block.
// Input words arrive on the s_ stream: tuser selects an add (0) or a read (1),
// tdata carries the key, its length and the row and column of a read. Every
// input word yields one output word on the m_ stream with the counter read
// (zero for an add) and the number of keys added so far.
// Configuration is written through cfg_we / cfg_index / cfg_data: index 0 sets
// the rows in use, index 1 the counters per row. Write it only while idle.
// After reset the counter memory is cleared one entry a cycle, MAX_ROWS times
// the counter row span (8192 entries by default); s_tready stays low meanwhile.
// An add first mixes the key blocks, then issues a column hash and a sign hash
// for each row through one shared hash pipeline, one a cycle; the column goes
// through a four-stage remainder pipeline and the counter is read, adjusted and
// written back. The time an add takes grows with the rows in use, as each row
// sends two hashes through the shared pipeline. A read passes through the READ
// and READ_WAIT states while the memory port returns the counter.
// Items are handled one at a time. The output word sits in a register, so a
// new input word is taken while it waits; if the receiver stalls, the next
// result waits inside the block until the output register is free.
module ams_sketch_update #(
  parameter int unsigned MAX_ROWS      = asu_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COUNTERS  = asu_pkg::MAX_COUNTERS_DEF,
  parameter int unsigned MAX_KEY_BYTES = asu_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // key_bytes[63:0], key_length[67:64], read_row[70:68], read_column[80:71]
  input  logic [asu_pkg::IN_DATA_W-1:0]   s_tdata,
  // operation
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // counter_value[31:0], items_added[63:32]
  output logic [asu_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [asu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W  = $clog2(MAX_COUNTERS);
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned DEPTH  = MAX_ROWS * (2 ** COL_W);

  // Configuration
  logic [asu_pkg::NROWS_W-1:0] rows_cfg;
  logic [asu_pkg::NCOLS_W-1:0] cols_cfg;
  logic [asu_pkg::NROWS_W-1:0] nrows;
  logic [asu_pkg::NCOLS_W-1:0] ncols;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= asu_pkg::ROWS_RESET;
      cols_cfg <= asu_pkg::COUNTERS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asu_pkg::REG_ROWS:     rows_cfg <= cfg_data[asu_pkg::NROWS_W-1:0];
        asu_pkg::REG_COUNTERS: cols_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_cfg == '0) begin
      nrows = 4'd1;
    end else if (32'(rows_cfg) > MAX_ROWS) begin
      nrows = asu_pkg::NROWS_W'(MAX_ROWS);
    end else begin
      nrows = rows_cfg;
    end
    if (cols_cfg == '0) begin
      ncols = 11'd1;
    end else if (32'(cols_cfg) > MAX_COUNTERS) begin
      ncols = asu_pkg::NCOLS_W'(MAX_COUNTERS);
    end else begin
      ncols = cols_cfg;
    end
  end

  // Control
  asu_pkg::asu_state_t state, state_next;
  logic                s_accept;
  logic                out_load;
  logic                hash_in_valid;
  logic                clear_we;
  logic                read_sel;

  logic [ADDR_W-1:0]   clear_addr;
  logic                prep_cnt;
  logic [4:0]          issue_cnt;
  logic [4:0]          issue_last;
  logic [asu_pkg::NROWS_W-1:0] done_cnt;

  assign s_accept   = s_tvalid && s_tready;
  assign issue_last = 5'({nrows, 1'b0}) - 5'd1;

  always_comb begin
    state_next = state;
    unique case (state)
      asu_pkg::ST_CLEAR: begin
        if (clear_addr == ADDR_W'(DEPTH - 1)) state_next = asu_pkg::ST_IDLE;
      end
      asu_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_next = (s_tuser == asu_pkg::OP_READ) ? asu_pkg::ST_READ : asu_pkg::ST_PREP;
        end
      end
      asu_pkg::ST_PREP: begin
        if (prep_cnt) state_next = asu_pkg::ST_ISSUE;
      end
      asu_pkg::ST_ISSUE: begin
        if (issue_cnt == issue_last) state_next = asu_pkg::ST_DRAIN;
      end
      asu_pkg::ST_DRAIN: begin
        if (done_cnt == nrows) state_next = asu_pkg::ST_FINISH;
      end
      asu_pkg::ST_READ:      state_next = asu_pkg::ST_READ_WAIT;
      asu_pkg::ST_READ_WAIT: state_next = asu_pkg::ST_FINISH;
      asu_pkg::ST_FINISH: begin
        if (out_load) state_next = asu_pkg::ST_IDLE;
      end
      default: state_next = asu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = (state == asu_pkg::ST_IDLE);
    clear_we      = (state == asu_pkg::ST_CLEAR);
    hash_in_valid = (state == asu_pkg::ST_ISSUE);
    read_sel      = (state == asu_pkg::ST_READ);
    out_load      = (state == asu_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asu_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Latched input word, with the key cut to its length
  logic                         op_l;
  logic [31:0]                  word0_l, word1_l;
  logic [asu_pkg::LEN_W-1:0]    len_l;
  logic [asu_pkg::RROW_W-1:0]   rrow_l;
  logic [asu_pkg::RCOL_W-1:0]   rcol_l;
  logic [asu_pkg::LEN_W-1:0]    len_in;
  logic [asu_pkg::KEY_W-1:0]    key_masked;

  always_comb begin
    len_in = s_tdata[67:64];
    if (32'(len_in) > MAX_KEY_BYTES) begin
      len_in = asu_pkg::LEN_W'(MAX_KEY_BYTES);
    end
    for (int i = 0; i < 8; i++) begin
      key_masked[i*8 +: 8] = (i < int'(len_in)) ? s_tdata[i*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      op_l    <= s_tuser;
      word0_l <= key_masked[31:0];
      word1_l <= key_masked[63:32];
      len_l   <= len_in;
      rrow_l  <= s_tdata[70:68];
      rcol_l  <= s_tdata[80:71];
    end
  end

  // Counters of the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      prep_cnt   <= 1'b0;
      issue_cnt  <= '0;
    end else begin
      if (clear_we) clear_addr <= clear_addr + ADDR_W'(1);
      if (state == asu_pkg::ST_PREP) prep_cnt <= ~prep_cnt;
      if (hash_in_valid) begin
        issue_cnt <= (issue_cnt == issue_last) ? 5'd0 : issue_cnt + 5'd1;
      end
    end
  end

  // Hash issue: even slots hash the column with seed r, odd slots the sign
  // with seed rows + r.
  asu_pkg::hash_tag_t hash_in_tag, hash_out_tag;
  logic [31:0]        hash_seed;
  logic               hash_out_valid;
  logic [31:0]        hash_out;

  always_comb begin
    hash_in_tag.is_sign = issue_cnt[0];
    hash_in_tag.row     = issue_cnt[4:1];
    hash_seed = issue_cnt[0] ? 32'(nrows) + 32'(issue_cnt[4:1]) : 32'(issue_cnt[4:1]);
  end

  asu_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .key_word0 (word0_l),
    .key_word1 (word1_l),
    .key_len   (len_l),
    .in_valid  (hash_in_valid),
    .in_seed   (hash_seed),
    .in_tag    (hash_in_tag),
    .out_valid (hash_out_valid),
    .out_hash  (hash_out),
    .out_tag   (hash_out_tag)
  );

  // The sign of a row lands here well before its column leaves the remainder pipe.
  logic [15:0] sign_bits;

  always_ff @(posedge clk) begin
    if (hash_out_valid && hash_out_tag.is_sign) begin
      sign_bits[hash_out_tag.row] <= hash_out[0];
    end
  end

  logic                        mod_out_valid;
  logic [asu_pkg::NCOLS_W-1:0] mod_out_rem;
  logic [asu_pkg::NROWS_W-1:0] mod_out_row;

  asu_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .divisor   (ncols),
    .in_valid  (hash_out_valid && !hash_out_tag.is_sign),
    .in_value  (hash_out),
    .in_row    (hash_out_tag.row),
    .out_valid (mod_out_valid),
    .out_rem   (mod_out_rem),
    .out_row   (mod_out_row)
  );

  // Counter read-modify-write. Rows of one add hit distinct entries and adds
  // do not overlap, so no forwarding is needed.
  logic [31:0]       upd_row32, upd_col32, rd_row32, rd_col32;
  logic [ADDR_W-1:0] upd_rd_addr, read_addr, mem_rd_addr, mem_wr_addr;
  logic [31:0]       mem_rd_data, mem_wr_data;
  logic              mem_wr_en;
  logic              upd_valid;
  logic [ADDR_W-1:0] upd_addr;
  logic              upd_sign;

  always_comb begin
    upd_row32   = 32'(mod_out_row);
    upd_col32   = 32'(mod_out_rem);
    rd_row32    = 32'(rrow_l);
    rd_col32    = 32'(rcol_l);
    upd_rd_addr = {upd_row32[ROW_W-1:0], upd_col32[COL_W-1:0]};
    read_addr   = {rd_row32[ROW_W-1:0], rd_col32[COL_W-1:0]};
    mem_rd_addr = read_sel ? read_addr : upd_rd_addr;
    if (clear_we) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clear_addr;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = upd_valid;
      mem_wr_addr = upd_addr;
      mem_wr_data = upd_sign ? mem_rd_data + 32'd1 : mem_rd_data - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else begin
      upd_valid <= mod_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    upd_addr <= upd_rd_addr;
    upd_sign <= sign_bits[mod_out_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_cnt <= '0;
    end else if (s_accept) begin
      done_cnt <= '0;
    end else if (upd_valid) begin
      done_cnt <= done_cnt + asu_pkg::NROWS_W'(1);
    end
  end

  asu_counters #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_counters (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Result and output register
  logic signed [31:0] result_value;
  logic [31:0]        item_count;
  logic [31:0]        items_next;
  logic               in_range;

  assign in_range   = (32'(rrow_l) < 32'(nrows)) && (32'(rcol_l) < 32'(ncols));
  assign items_next = (op_l == asu_pkg::OP_ADD) ? item_count + 32'd1 : item_count;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      result_value <= '0;
    end else if (state == asu_pkg::ST_READ_WAIT) begin
      result_value <= in_range ? mem_rd_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        item_count <= items_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {items_next, result_value};
    end
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  import asu_pkg::OP_ADD;
  import asu_pkg::OP_READ;
  import asu_pkg::REG_ROWS;
  import asu_pkg::REG_COUNTERS;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned PHASE_WORDS  = 154;
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned POOL_SIZE    = 16;
  localparam int unsigned SKETCH_ROWS  = asu_pkg::MAX_ROWS_DEF;
  localparam int unsigned SKETCH_COLS  = asu_pkg::MAX_COUNTERS_DEF;
  localparam int unsigned KEY_BYTES    = asu_pkg::MAX_KEY_BYTES_DEF;
  localparam logic [asu_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [asu_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2    = 32'h1b873593;
  localparam logic [31:0] ROUND_ADD = 32'he6546b64;
  localparam logic [31:0] FMIX_C1   = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2   = 32'hc2b2ae35;

  typedef enum logic {STEP_WORD, STEP_REG} step_kind_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] value;
  } sketch_result_t;

  typedef struct packed {
    step_kind_t  kind;
    logic        op;
    logic [63:0] key;
    logic [3:0]  len;
    logic [2:0]  row;
    logic [9:0]  col;
    logic [1:0]  reg_index;
    logic [10:0] reg_data;
    logic        typed;
    logic [31:0] value;
    logic [31:0] count;
  } step_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [asu_pkg::IN_DATA_W-1:0]    s_tdata = '0;
  logic                             s_tuser = OP_ADD;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [asu_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                             cfg_we = 1'b0;
  logic [asu_pkg::CFG_IDX_W-1:0]    cfg_index = REG_ROWS;
  logic [asu_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  ams_sketch_update uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the sketch and its configuration
  logic [31:0]    shadow_counters [0:SKETCH_ROWS*SKETCH_COLS-1];
  logic [31:0]    shadow_count;
  logic [3:0]     shadow_rows;
  logic [10:0]    shadow_cols;
  sketch_result_t expected_readings [$];

  int unsigned    failures = 0;
  int unsigned    cycle_count = 0;
  int unsigned    word_count = 0;
  bit             sender_steady = 1'b0;
  bit             receiver_steady = 1'b0;
  bit             hold_request = 1'b0;

  logic [63:0]    pool_key [0:POOL_SIZE-1];
  logic [3:0]     pool_len [0:POOL_SIZE-1];
  int unsigned    pool_fill = 0;
  int unsigned    pool_next = 0;

  step_t          directed_steps [0:21];
  logic [10:0]    phase_rows [0:PHASE_COUNT-1] = '{11'd8, 11'd1, 11'd0, 11'd15,
                                                    11'h7F3, 11'd8, 11'd1, 11'd5};
  logic [10:0]    phase_cols [0:PHASE_COUNT-1] = '{11'd1024, 11'd1, 11'd0, 11'd2047,
                                                    11'd7, 11'd1, 11'd1024, 11'd600};

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    k = k * MIX_C1;
    k = {k[16:0], k[31:17]};
    return k * MIX_C2;
  endfunction

  function automatic logic [31:0] murmur32(input logic [63:0] key, input int unsigned nbytes,
                                           input logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] k;
    int unsigned pos;
    int unsigned rem;
    h = seed;
    pos = 0;
    while (pos + 4 <= nbytes) begin
      h ^= scramble_block(key[pos*8 +: 32]);
      h = {h[18:0], h[31:19]};
      h = h * 5 + ROUND_ADD;
      pos += 4;
    end
    rem = nbytes & 3;
    if (rem != 0) begin
      k = key[pos*8 +: 32] & (32'hFFFF_FFFF >> (32 - 8 * rem));
      h ^= scramble_block(k);
    end
    h ^= 32'(nbytes);
    h ^= h >> 16;
    h = h * FMIX_C1;
    h ^= h >> 13;
    h = h * FMIX_C2;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic int unsigned eff_rows();
    if (shadow_rows == 0) return 1;
    if (shadow_rows > SKETCH_ROWS) return SKETCH_ROWS;
    return shadow_rows;
  endfunction

  function automatic int unsigned eff_cols();
    if (shadow_cols == 0) return 1;
    if (shadow_cols > SKETCH_COLS) return SKETCH_COLS;
    return shadow_cols;
  endfunction

  // Applies one word to the shadow sketch and returns the word the block should send back
  function automatic sketch_result_t sketch_apply(input logic op, input logic [63:0] key,
                                                  input logic [3:0] len, input logic [2:0] row,
                                                  input logic [9:0] col);
    sketch_result_t res;
    int unsigned nrows;
    int unsigned ncols;
    int unsigned nbytes;
    int unsigned c;
    int unsigned idx;
    logic [31:0] sign_hash;
    nrows = eff_rows();
    ncols = eff_cols();
    res.value = '0;
    if (op == OP_ADD) begin
      nbytes = (len > KEY_BYTES) ? KEY_BYTES : len;
      for (int unsigned r = 0; r < nrows; r++) begin
        c = murmur32(key, nbytes, r) % ncols;
        sign_hash = murmur32(key, nbytes, nrows + r);
        idx = r * SKETCH_COLS + c;
        if (sign_hash[0]) shadow_counters[idx] = shadow_counters[idx] + 1;
        else shadow_counters[idx] = shadow_counters[idx] - 1;
      end
      shadow_count = shadow_count + 1;
    end else if (row < nrows && col < ncols) begin
      res.value = shadow_counters[row * SKETCH_COLS + col];
    end
    res.count = shadow_count;
    return res;
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic wait_drained();
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic offer_word(input logic op, input logic [63:0] key, input logic [3:0] len,
                            input logic [2:0] row, input logic [9:0] col,
                            input logic typed, input sketch_result_t typed_res);
    int unsigned gap;
    sketch_result_t predicted;
    if (word_count % 64 == 0) sender_steady = ($urandom_range(0, 3) == 0);
    word_count++;
    gap = sender_steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, col, row, len, key};
    do @(posedge clk); while (s_tready !== 1'b1);
    predicted = sketch_apply(op, key, len, row, col);
    expected_readings.push_back(typed ? typed_res : predicted);
  endtask

  // Registers change only with nothing in flight; every word yields a result, so an
  // empty queue of expectations means the block is idle.
  task automatic write_reg(input logic [1:0] index, input logic [10:0] data);
    s_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == REG_ROWS) shadow_rows = data[3:0];
    else if (index == REG_COUNTERS) shadow_cols = data;
  endtask

  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    forever begin
      if (taken % 64 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      stall = receiver_steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      taken++;
      // A long hold-off lets the block back up until it stalls its input.
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    sketch_result_t want;
    sketch_result_t got;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got = m_tdata;
      if (expected_readings.size() == 0) begin
        report_failure($sformatf("unexpected word: counter %0d, items %0d",
                                 $signed(got.value), got.count));
      end else begin
        want = expected_readings.pop_front();
        if (got !== want) begin
          report_failure($sformatf("counter %0d items %0d, expected counter %0d items %0d",
                                   $signed(got.value), got.count,
                                   $signed(want.value), want.count));
        end
      end
    end
  end

  initial begin : stimulus
    step_t          step;
    sketch_result_t typed_res;
    logic           op;
    logic [63:0]    key;
    logic [63:0]    junk_mask;
    logic [3:0]     len;
    logic [2:0]     row;
    logic [9:0]     col;
    int unsigned    pick;
    int unsigned    nbytes;

    for (int unsigned i = 0; i < SKETCH_ROWS * SKETCH_COLS; i++) shadow_counters[i] = '0;
    shadow_count = '0;
    shadow_rows  = asu_pkg::ROWS_RESET;
    shadow_cols  = asu_pkg::COUNTERS_RESET;

    // kind, op, key, len, row, col, reg index, reg data, typed, counter, items
    directed_steps = '{
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd0, 10'd0, REG_ROWS, 11'd0, 1'b1, 32'd0, 32'd0},
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd7, 10'd1023, REG_ROWS, 11'd0, 1'b1, 32'd0, 32'd0},
      '{STEP_WORD, OP_ADD, 64'h0, 4'd0, 3'd0, 10'd0, REG_ROWS, 11'd0, 1'b1, 32'd0, 32'd1},
      '{STEP_WORD, OP_ADD, '1, 4'd8, 3'd7, 10'd1023, REG_ROWS, 11'd0, 1'b1, 32'd0, 32'd2},
      '{STEP_WORD, OP_ADD, '1, 4'd15, 3'd0, 10'd0, REG_ROWS, 11'd0, 1'b1, 32'd0, 32'd3},
      '{STEP_WORD, OP_ADD, 64'h0123456789abcdef, 4'd1, 3'd0, 10'd0, REG_ROWS, 11'd0,
        1'b1, 32'd0, 32'd4},
      '{STEP_WORD, OP_ADD, 64'h0123456789abcdef, 4'd3, 3'd0, 10'd0, REG_ROWS, 11'd0,
        1'b1, 32'd0, 32'd5},
      '{STEP_WORD, OP_ADD, 64'h0123456789abcdef, 4'd4, 3'd0, 10'd0, REG_ROWS, 11'd0,
        1'b1, 32'd0, 32'd6},
      '{STEP_WORD, OP_ADD, 64'h0123456789abcdef, 4'd5, 3'd0, 10'd0, REG_ROWS, 11'd0,
        1'b1, 32'd0, 32'd7},
      '{STEP_WORD, OP_ADD, 64'hfedcba9876543210, 4'd7, 3'd0, 10'd0, REG_ROWS, 11'd0,
        1'b1, 32'd0, 32'd8},
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd0, 10'd0, REG_ROWS, 11'd0, 1'b0, 32'd0, 32'd0},
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd3, 10'd512, REG_ROWS, 11'd0, 1'b0, 32'd0, 32'd0},
      '{STEP_WORD, OP_READ, '1, 4'd15, 3'd7, 10'd1023, REG_ROWS, 11'd0, 1'b0, 32'd0, 32'd0},
      '{STEP_REG, OP_ADD, 64'h0, 4'd0, 3'd0, 10'd0, REG_ROWS, 11'd2, 1'b0, 32'd0, 32'd0},
      '{STEP_REG, OP_ADD, 64'h0, 4'd0, 3'd0, 10'd0, REG_COUNTERS, 11'd5, 1'b0, 32'd0, 32'd0},
      '{STEP_REG, OP_ADD, 64'h0, 4'd0, 3'd0, 10'd0, REG_SPARE_LO, 11'h7FF, 1'b0, 32'd0, 32'd0},
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd2, 10'd0, REG_ROWS, 11'd0, 1'b1, 32'd0, 32'd8},
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd0, 10'd5, REG_ROWS, 11'd0, 1'b1, 32'd0, 32'd8},
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd1, 10'd1023, REG_ROWS, 11'd0, 1'b1, 32'd0, 32'd8},
      '{STEP_WORD, OP_ADD, 64'hdeadbeefcafef00d, 4'd6, 3'd0, 10'd0, REG_ROWS, 11'd0,
        1'b1, 32'd0, 32'd9},
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd0, 10'd0, REG_ROWS, 11'd0, 1'b0, 32'd0, 32'd0},
      '{STEP_WORD, OP_READ, 64'h0, 4'd0, 3'd1, 10'd4, REG_ROWS, 11'd0, 1'b0, 32'd0, 32'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      step = directed_steps[i];
      if (step.kind == STEP_REG) begin
        write_reg(step.reg_index, step.reg_data);
      end else begin
        typed_res.value = step.value;
        typed_res.count = step.count;
        offer_word(step.op, step.key, step.len, step.row, step.col, step.typed, typed_res);
      end
    end

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      write_reg(REG_ROWS, phase_rows[p]);
      write_reg(REG_COUNTERS, phase_cols[p]);
      if (p == 0) write_reg(REG_SPARE_HI, 11'($urandom));
      for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
        if (p == 1 && i == 70) begin
          s_tvalid <= 1'b0;
          wait_drained();
        end
        if (p == 3 && i == 20) hold_request = 1'b1;

        op  = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_READ;
        key = {$urandom, $urandom};
        len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        row = 3'($urandom_range(0, 7));
        col = 10'($urandom_range(0, 1023));
        // Most words revisit recent keys, with junk above the key length, so that
        // counters build up and reads land on columns that were hit.
        if (pool_fill != 0 && $urandom_range(0, 99) < 60) begin
          pick      = $urandom_range(0, pool_fill - 1);
          len       = pool_len[pick];
          nbytes    = (len > KEY_BYTES) ? KEY_BYTES : len;
          junk_mask = (nbytes == 8) ? 64'd0 : ~((64'd1 << (nbytes * 8)) - 64'd1);
          key       = pool_key[pick] ^ (key & junk_mask);
          if (op == OP_READ) begin
            row = 3'($urandom_range(0, eff_rows() - 1));
            col = 10'(murmur32(key, nbytes, row) % eff_cols());
          end
        end else if (op == OP_ADD) begin
          pool_key[pool_next] = key;
          pool_len[pool_next] = len;
          pool_next = (pool_next + 1) % POOL_SIZE;
          if (pool_fill < POOL_SIZE) pool_fill++;
        end
        offer_word(op, key, len, row, col, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", expected_readings.size()));
    end
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
